>>> hdl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    // Field widths of the stream items.
    localparam int ADDR_W = 32;
    localparam int LEN_W = 6;
    localparam int IDX_W = 6;
    localparam int MAX_LEN = 32;
    localparam int DEF_TABLE_DEPTH = 64;

    // Bit widths of the packed input and output data words, rounded up to whole bytes.
    localparam int S_TDATA_W = ((ADDR_W + LEN_W + IDX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + 7) / 8) * 8;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_lpm_cmd;

    // Write bus broadcast to every cell by a load beat.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_lpm_wr;

    // Lookup token that travels one cell per cycle along the row while the row is not held.
    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] address;
        logic              hit;
        logic [IDX_W-1:0]  best_idx;
        logic [LEN_W-1:0]  best_len;
    } t_lpm_tok;

    // Network mask of a prefix length that is already limited to 0..32.
    function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] shift;
        logic [ADDR_W-1:0] mask;
        shift = LEN_W'(ADDR_W) - len;
        if (len == '0) begin
            mask = '0;
        end else begin
            mask = {ADDR_W{1'b1}} << shift;
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

>>> hdl/longest_prefix_match_table.sv
// IPv4 longest-prefix-match routing table built as a row of TABLE_DEPTH cells.
// Input stream: tuser carries the item kind (0 load, 1 lookup); tdata carries
// address, prefix length and slot index. A load beat writes its slot and
// gives no output beat. A lookup beat sends a token down the row, one cell per
// cycle while the row is not held, each cell keeping the longest matching
// prefix seen so far (lowest slot wins ties).
// Output stream: tuser is the found flag, tdata the winning slot index.
// A lookup result passes through the token register of every cell and then
// the output register. The block takes no new item while a lookup is in the
// row, so a new lookup is not taken before the last one has left the row;
// loads are taken at one per cycle while no lookup is in the row.
// A new item is taken while a finished result waits in the output register.
// If the receiver stalls and a second result reaches the end of the row, the
// whole row holds until the output register frees up.
// Reset clears every slot valid bit and empties the row and output register.
`default_nettype none

module longest_prefix_match_table #(
    parameter int TABLE_DEPTH = lpm_pkg::DEF_TABLE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // [31:0] address, [37:32] prefix_len, [43:38] entry_index, rest zero
    input  wire  [lpm_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] cmd
    input  wire                              s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [5:0] match_index, rest zero
    output logic [lpm_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] found
    output logic                             m_tuser
);
    import lpm_pkg::*;

    logic              r_busy;
    logic              r_out_valid;
    logic              r_out_found;
    logic [IDX_W-1:0]  r_out_idx;
    logic              w_accept;
    logic              w_advance;
    logic              w_tail_done;
    logic [LEN_W-1:0]  w_len_in;
    t_lpm_wr           w_wr;
    t_lpm_tok          w_head;
    t_lpm_tok          w_tok [TABLE_DEPTH];

    assign s_tready = !r_busy;
    assign w_accept = s_tvalid && s_tready;

    // Saturate the loaded prefix length to a full mask.
    assign w_len_in = (s_tdata[ADDR_W +: LEN_W] > LEN_W'(MAX_LEN)) ?
                      LEN_W'(MAX_LEN) : s_tdata[ADDR_W +: LEN_W];

    // Load beats go out on the write bus to all cells.
    always_comb begin
        w_wr.en = w_accept && (t_lpm_cmd'(s_tuser) == CMD_LOAD);
        w_wr.index = s_tdata[ADDR_W + LEN_W +: IDX_W];
        w_wr.address = s_tdata[ADDR_W-1:0];
        w_wr.length = w_len_in;
    end

    // Lookup beats enter the row as a fresh token.
    always_comb begin
        w_head.active = w_accept && (t_lpm_cmd'(s_tuser) == CMD_LOOKUP);
        w_head.address = s_tdata[ADDR_W-1:0];
        w_head.hit = 1'b0;
        w_head.best_idx = '0;
        w_head.best_len = '0;
    end

    // The row holds only while a result at its end cannot leave.
    assign w_tail_done = w_tok[TABLE_DEPTH-1].active;
    assign w_advance = !(w_tail_done && r_out_valid && !m_tready);

    // Row of cells, each passing its token to the next one.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            lpm_cell #(.CELL_IDX(g)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_advance (w_advance),
                .i_wr      (w_wr),
                .i_tok     (w_head),
                .o_tok     (w_tok[g])
            );
        end else begin : g_next
            lpm_cell #(.CELL_IDX(g)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_advance (w_advance),
                .i_wr      (w_wr),
                .i_tok     (w_tok[g-1]),
                .o_tok     (w_tok[g])
            );
        end
    end

    // Busy flag and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_head.active) begin
                r_busy <= 1'b1;
            end else if (w_tail_done && w_advance) begin
                r_busy <= 1'b0;
            end
            if (w_tail_done && w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_tail_done && w_advance) begin
            r_out_found <= w_tok[TABLE_DEPTH-1].hit;
            r_out_idx <= w_tok[TABLE_DEPTH-1].best_idx;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser = r_out_found;
    assign m_tdata = M_TDATA_W'(r_out_idx);

endmodule

`default_nettype wire

>>> hdl/lpm_cell.sv
`default_nettype none

module lpm_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_advance,
    input  wire lpm_pkg::t_lpm_wr    i_wr,
    input  wire lpm_pkg::t_lpm_tok   i_tok,
    output lpm_pkg::t_lpm_tok        o_tok
);
    import lpm_pkg::*;

    // The slot number of this cell as seen on the 6-bit index field.
    localparam bit IDX_REACH = (CELL_IDX < (1 << IDX_W));
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic              r_valid;
    logic [ADDR_W-1:0] r_address;
    logic [LEN_W-1:0]  r_length;
    t_lpm_tok          r_tok;
    t_lpm_tok          n_tok;
    logic              w_sel;
    logic [ADDR_W-1:0] w_mask;
    logic              w_match;

    assign w_sel = IDX_REACH && i_wr.en && (i_wr.index == MY_IDX);

    // Compare the passing token with the stored prefix.
    always_comb begin
        w_mask = net_mask(r_length);
        w_match = r_valid && ((r_address & w_mask) == (i_tok.address & w_mask));
        n_tok = i_tok;
        if (i_tok.active && w_match && (!i_tok.hit || (r_length > i_tok.best_len))) begin
            n_tok.hit = 1'b1;
            n_tok.best_idx = MY_IDX;
            n_tok.best_len = r_length;
        end
    end

    // Stored slot: the valid bit is reset, the prefix itself is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            r_valid <= 1'b1;
        end
        if (w_sel) begin
            r_address <= i_wr.address;
            r_length <= i_wr.length;
        end
    end

    // Token stage handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else if (i_advance) begin
            r_tok.active <= n_tok.active;
        end
        if (i_advance) begin
            r_tok.address <= n_tok.address;
            r_tok.hit <= n_tok.hit;
            r_tok.best_idx <= n_tok.best_idx;
            r_tok.best_len <= n_tok.best_len;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

>>> tb/lpm_route_checker.sv
`timescale 1ns / 100ps

module lpm_route_checker #(
    parameter int TABLE_DEPTH = lpm_pkg::DEF_TABLE_DEPTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    input  wire                            i_s_tready,
    // [31:0] address, [37:32] prefix_len, [43:38] entry_index, rest zero
    input  wire  [lpm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [0] cmd
    input  wire                            i_s_tuser,
    input  wire                            i_m_tvalid,
    input  wire                            i_m_tready,
    // [5:0] match_index, rest zero
    input  wire  [lpm_pkg::M_TDATA_W-1:0]  i_m_tdata,
    // [0] found
    input  wire                            i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    import lpm_pkg::*;

    // One expected lookup answer, with the address that asked for it.
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic              found;
        logic [IDX_W-1:0]  index;
    } t_route;

    // Shadow copy of the routing table.
    logic [ADDR_W-1:0] table_addr  [TABLE_DEPTH];
    logic [LEN_W-1:0]  table_len   [TABLE_DEPTH];
    logic              table_valid [TABLE_DEPTH];

    t_route route_queue [$];
    int     mismatches = 0;

    // Longest valid prefix covering the address; the lowest slot wins a tie.
    function automatic t_route best_route(input logic [ADDR_W-1:0] dest);
        t_route            best;
        logic [ADDR_W-1:0] mask;
        logic [LEN_W-1:0]  best_len;
        best = '0;
        best.dest = dest;
        best_len = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (table_len[i] == '0) begin
                mask = '0;
            end else begin
                mask = {ADDR_W{1'b1}} << (ADDR_W - int'(table_len[i]));
            end
            if (table_valid[i] && ((table_addr[i] & mask) == (dest & mask))
                    && (!best.found || table_len[i] > best_len)) begin
                best.found = 1'b1;
                best.index = i[IDX_W-1:0];
                best_len = table_len[i];
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin : route_check
        t_route           want;
        logic [IDX_W-1:0] slot;
        logic [LEN_W-1:0] plen;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                table_valid[i] = 1'b0;
            end
            route_queue.delete();
        end else begin
            // Result beat: compare with the oldest outstanding lookup.
            if (i_m_tvalid && i_m_tready) begin
                if (route_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result beat found=%0b index=%0d",
                                 $time, i_m_tuser, i_m_tdata[IDX_W-1:0]);
                    end
                end else begin
                    want = route_queue.pop_front();
                    if (i_m_tuser !== want.found
                            || i_m_tdata[IDX_W-1:0] !== want.index) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: route mismatch for %h: expected found=%0b ",
                                      "index=%0d, got found=%0b index=%0d"},
                                     $time, want.dest, want.found, want.index,
                                     i_m_tuser, i_m_tdata[IDX_W-1:0]);
                        end
                    end
                end
            end

            // Input beat: a load updates the table, a lookup queues its answer.
            if (i_s_tvalid && i_s_tready) begin
                plen = i_s_tdata[ADDR_W +: LEN_W];
                slot = i_s_tdata[ADDR_W+LEN_W +: IDX_W];
                if (t_lpm_cmd'(i_s_tuser) == CMD_LOAD) begin
                    if (int'(slot) < TABLE_DEPTH) begin
                        table_addr[slot] = i_s_tdata[ADDR_W-1:0];
                        table_len[slot] = (plen > MAX_LEN) ? LEN_W'(MAX_LEN) : plen;
                        table_valid[slot] = 1'b1;
                    end
                end else begin
                    route_queue.push_back(best_route(i_s_tdata[ADDR_W-1:0]));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending <= route_queue.size();
    end

endmodule

>>> tb/longest_prefix_match_table_tb.sv
`timescale 1ns / 100ps

module longest_prefix_match_table_tb;
    import lpm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = DEF_TABLE_DEPTH + 16;
    localparam int POOL_SIZE = 6;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    wire                  m_tvalid;
    logic                 m_tready;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tuser;

    int fail_count;
    int pending_routes;
    int idle_max = 18;
    int cycle_count = 0;

    // Stimulus bookkeeping: network bases for loads and lookups, and the loaded slots used to aim lookups.
    logic [ADDR_W-1:0] net_pool    [POOL_SIZE];
    logic [ADDR_W-1:0] loaded_addr [DEF_TABLE_DEPTH];
    logic              loaded_slot [DEF_TABLE_DEPTH];
    int                last_slot = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    longest_prefix_match_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lpm_route_checker route_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_routes)
    );

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("longest_prefix_match_table_tb failed");
            $finish;
        end
    end

    // Present one beat after a random gap and hold it until it is taken.
    task automatic send_item(input t_lpm_cmd kind, input logic [ADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] plen, input logic [IDX_W-1:0] slot);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = $urandom_range(0, idle_max);
        word = '0;
        word[ADDR_W-1:0] = addr;
        word[ADDR_W +: LEN_W] = plen;
        word[ADDR_W+LEN_W +: IDX_W] = slot;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= kind;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (kind == CMD_LOAD) begin
            loaded_slot[slot] = 1'b1;
            loaded_addr[slot] = addr;
            last_slot = slot;
        end
    endtask

    // Stop sending and wait until every lookup has been answered.
    task automatic drain_routes();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_routes != 0) @(posedge i_clk);
    endtask

    // Loads cluster around a few network bases so prefixes nest and overlap;
    // most lookups land inside a loaded prefix with random host bits.
    task automatic random_item();
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
        int                slot;
        int                pick;
        pick = $urandom_range(0, 9);
        slot = $urandom_range(0, DEF_TABLE_DEPTH - 1);
        if ($urandom_range(0, 99) < 35) begin
            if (pick < 8) begin
                addr = net_pool[$urandom_range(0, POOL_SIZE - 1)]
                       ^ ($urandom >> $urandom_range(2, 32));
            end else begin
                addr = $urandom;
            end
            case ($urandom_range(0, 19))
                0: plen = '0;
                1: plen = LEN_W'($urandom_range(MAX_LEN + 1, 63));
                2: plen = LEN_W'(MAX_LEN);
                default: plen = LEN_W'($urandom_range(1, MAX_LEN));
            endcase
            send_item(CMD_LOAD, addr, plen, slot[IDX_W-1:0]);
        end else begin
            if (!loaded_slot[slot]) begin
                slot = last_slot;
            end
            if (pick < 7) begin
                addr = loaded_addr[slot] ^ ($urandom >> $urandom_range(0, 32));
            end else if (pick == 7) begin
                addr = $urandom;
            end else begin
                addr = net_pool[$urandom_range(0, POOL_SIZE - 1)]
                       ^ ($urandom >> $urandom_range(8, 32));
            end
            // Length and slot fields are don't-care on a lookup.
            send_item(CMD_LOOKUP, addr, LEN_W'($urandom), IDX_W'($urandom));
        end
    endtask

    // Result side: random stall before each beat.
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
            loaded_slot[i] = 1'b0;
            loaded_addr[i] = '0;
        end
        foreach (net_pool[k]) begin
            net_pool[k] = $urandom;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Lookups on an empty table find nothing.
        send_item(CMD_LOOKUP, 32'h0000_0000, '0, '0);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '1, '1);
        // A zero-length prefix matches every address, whatever its address bits.
        send_item(CMD_LOAD, 32'hDEAD_BEEF, 6'd0, 6'd1);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        // A host route in the top slot beats the default route.
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 6'd32, 6'd63);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFE, '0, '0);
        // Equal lengths: the lower slot wins; host bits of the prefix are ignored.
        send_item(CMD_LOAD, 32'h0A00_0000, 6'd8, 6'd10);
        send_item(CMD_LOAD, 32'h0AFF_FFFF, 6'd8, 6'd5);
        send_item(CMD_LOOKUP, 32'h0A12_3456, '0, '0);
        send_item(CMD_LOAD, 32'h0A12_0000, 6'd16, 6'd20);
        send_item(CMD_LOOKUP, 32'h0A12_FFFF, '0, '0);
        // Lengths above 32 saturate to a full mask, so these two slots tie.
        send_item(CMD_LOAD, 32'hC0A8_0101, 6'd63, 6'd30);
        send_item(CMD_LOAD, 32'hC0A8_0101, 6'd33, 6'd31);
        send_item(CMD_LOOKUP, 32'hC0A8_0101, '0, '0);
        send_item(CMD_LOOKUP, 32'hC0A8_0100, '0, '0);
        // Overwriting the default route leaves the lower half unrouted.
        send_item(CMD_LOAD, 32'h8000_0000, 6'd1, 6'd1);
        send_item(CMD_LOOKUP, 32'h7FFF_FFFF, '0, '0);
        send_item(CMD_LOOKUP, 32'h8000_0000, '0, '0);
        send_item(CMD_LOAD, 32'h5555_5555, 6'd31, 6'd42);
        send_item(CMD_LOOKUP, 32'h5555_5554, '0, '0);
        send_item(CMD_LOAD, 32'hAAAA_AAAA, 6'd1, 6'd21);
        send_item(CMD_LOOKUP, 32'hC000_0000, '0, '0);
        drain_routes();

        // Random phases with different idling, each drained at its end.
        for (int phase = 0; phase < 4; phase++) begin
            idle_max = (phase == 1) ? 0 : ((phase == 3) ? 4 : 18);
            repeat (470) random_item();
            drain_routes();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_routes == 0) begin
            $display("longest_prefix_match_table_tb passed");
        end else begin
            $display("longest_prefix_match_table_tb failed");
        end
        $finish;
    end

endmodule
